// File: hw/rtl/egd_pkg.sv
// Shared types, constants and helpers for the Elias gamma/delta bit packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package egd_pkg;

  localparam int WORD_W  = 32;
  localparam int CODE_W  = 64;
  localparam int LEN_W   = 6;
  localparam int NBITS_W = 6;
  localparam int FILL_W  = 5;
  localparam int BUF_W   = 31;
  localparam int CNT_W   = 21;

  localparam logic [CNT_W-1:0] MAX_WORDS    = 21'd1048576;
  localparam logic [CNT_W-1:0] CAPACITY_RST = 21'd1048576;

  // Request kinds
  localparam logic [1:0] REQ_RAW   = 2'd0;
  localparam logic [1:0] REQ_GAMMA = 2'd1;
  localparam logic [1:0] REQ_DELTA = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NBITS    = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [WORD_W-1:0]  value;
    logic [NBITS_W-1:0] nbits;
    logic               flush_after;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CODE_W-1:0] code;   // right-aligned code bits
    logic [LEN_W-1:0]  len;
  } code_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        n;      // words produced
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [BUF_W-1:0]  buf_next;
    logic [FILL_W-1:0] fill_next;
  } pack_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              word_valid;
    logic              last;
    logic [1:0]        status;
    logic [CNT_W-1:0]  words_written;
  } result_t;

  // Position of the highest set bit, 0 for zero input.
  function automatic logic [4:0] msb_index(input logic [WORD_W-1:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 1; i < WORD_W; i++) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/egd_code_gen.sv
// Code generator: raw, Elias gamma and Elias delta code words with lengths.
// Depends on egd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egd_code_gen
  import egd_pkg::*;
(
  input  item_t item,
  output code_t cg
);

  logic [WORD_W-1:0] v;
  logic [4:0]        d;
  logic [5:0]        g;
  logic [4:0]        e_full;
  logic [2:0]        e;
  logic [CODE_W-1:0] raw_mask;
  logic [WORD_W-1:0] low_d;
  logic              all_ones;

  always_comb begin
    v        = item.value + 32'd1;
    d        = msb_index(v);
    g        = {1'b0, d} + 6'd1;
    e_full   = msb_index({26'd0, g});
    e        = e_full[2:0];
    raw_mask = ~({CODE_W{1'b1}} << item.nbits);
    low_d    = v & ~({WORD_W{1'b1}} << d);
    all_ones = &item.value;

    cg = '0;
    case (item.req_type)
      REQ_RAW: begin
        if (item.nbits > 6'd32) begin
          cg.status = ST_NBITS;
        end else begin
          cg.code = {32'd0, item.value} & raw_mask;
          cg.len  = item.nbits;
        end
      end
      REQ_GAMMA: begin
        if (all_ones) begin
          cg.status = ST_RANGE;
        end else begin
          cg.code = {32'd0, v};
          cg.len  = {d, 1'b1};                 // 2d+1
        end
      end
      REQ_DELTA: begin
        if (all_ones) begin
          cg.status = ST_RANGE;
        end else begin
          // gamma of d+1, then the d bits below the leading one of v
          cg.code = ({58'd0, g} << d) | {32'd0, low_d};
          cg.len  = {2'd0, e, 1'b1} + {1'b0, d};
        end
      end
      default: begin
        cg.status = ST_RANGE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/egd_pack.sv
// Bit packer: merges pending bits with a new code, cuts 32-bit words,
// checks capacity and flush limits. Depends on egd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egd_pack
  import egd_pkg::*;
(
  input  code_t             cg,
  input  logic              flush,
  input  logic [BUF_W-1:0]  bit_buf,
  input  logic [FILL_W-1:0] fill,
  input  logic [CNT_W-1:0]  word_count,
  input  logic [CNT_W-1:0]  limit,
  output pack_t             pk
);

  logic [6:0]        total;
  logic [1:0]        full;
  logic [4:0]        rem;
  logic [1:0]        need;
  logic              overflow;
  logic [95:0]       stream_r;   // right-aligned pending + code bits
  logic [95:0]       stream_l;   // same, left-aligned (first bit at 95)
  logic [WORD_W-1:0] part;

  always_comb begin
    total    = {2'd0, fill} + {1'b0, cg.len};
    full     = total[6:5];
    rem      = total[4:0];
    need     = full + {1'b0, |rem};
    overflow = ({1'b0, word_count} + {20'd0, need}) > {1'b0, limit};

    stream_r = ({65'd0, bit_buf} << cg.len) | {32'd0, cg.code};
    stream_l = stream_r << (7'd96 - total);

    case (full)
      2'd0:    part = stream_l[95:64];
      2'd1:    part = stream_l[63:32];
      default: part = stream_l[31:0];
    endcase

    pk        = '0;
    pk.word0  = stream_l[95:64];
    pk.word1  = stream_l[63:32];
    if (cg.status != ST_OK) begin
      pk.status = cg.status;
    end else if (overflow || (flush && need > 2'd2)) begin
      pk.status = ST_OVERFLOW;
    end else begin
      pk.status = ST_OK;
    end

    if (flush) begin
      pk.n         = need;
      pk.buf_next  = '0;
      pk.fill_next = '0;
    end else begin
      pk.n         = full;
      pk.buf_next  = BUF_W'(part >> (6'd32 - {1'b0, rem}));
      pk.fill_next = rem;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/elias_gamma_delta_bit_packer.sv
// Top level of the Elias gamma/delta bit packer: input register, packer
// state, two-entry result queue. Depends on egd_pkg, egd_code_gen, egd_pack.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+---------------------------------
// s_*      | in  | s_tvalid / s_tready       | tdata value,nbits; tuser req_type;
//          |     |                           | tlast flush_after
// m_*      | out | m_tvalid / m_tready       | tdata word,words_written;
//          |     |                           | tuser word_valid,status; tlast last
// cfg_*    | in  | cfg_valid / cfg_ready     | cfg_data capacity_words
//
// One item per cycle sustained while m_tready is high and no item emits two words.
// Each item passes the input register, then the result queue, before its first result.
// Throughput is set by the output queue: an item that emits two words stalls the input.
// Reset (rst, synchronous) empties the input register and the result queue,
// clears bit buffer, fill and word count, and sets capacity to 1048576.
// Stalls on m_tready back up through the queue into s_tready.

module elias_gamma_delta_bit_packer
  import egd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,

  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [39:0]      s_tdata,   // [31:0] value, [37:32] nbits, [39:38] zero
  input  logic [1:0]       s_tuser,   // [1:0] req_type
  input  logic             s_tlast,   // flush_after

  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata,   // [31:0] word, [52:32] words_written, [55:53] zero
  output logic [2:0]       m_tuser,   // [0] word_valid, [2:1] status
  output logic             m_tlast,   // last

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data   // capacity_words
);

  // Configuration
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] limit;

  // Input register
  logic  in_valid;
  item_t in_item;

  // Packer state
  logic [BUF_W-1:0]  bit_buf;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  word_count;

  // Result queue, slot0 is the head
  result_t   slot0;
  result_t   slot1;
  logic [1:0] out_cnt;

  code_t   cg;
  pack_t   pk;
  result_t r0;
  result_t r1;
  logic [1:0] res_n;
  logic    out_free;
  logic    commit;
  logic    pop;
  logic    s_xfer;

  assign cfg_ready = 1'b1;
  assign limit     = (capacity < MAX_WORDS) ? capacity : MAX_WORDS;

  egd_code_gen u_code_gen (
    .item (in_item),
    .cg   (cg)
  );

  egd_pack u_pack (
    .cg         (cg),
    .flush      (in_item.flush_after),
    .bit_buf    (bit_buf),
    .fill       (fill),
    .word_count (word_count),
    .limit      (limit),
    .pk         (pk)
  );

  // Queue can take a new item's results if it is empty, or its one entry
  // leaves this cycle.
  assign pop      = m_tvalid && m_tready;
  assign out_free = (out_cnt == 2'd0) || (out_cnt == 2'd1 && m_tready);
  assign commit   = in_valid && out_free;
  assign s_tready = !in_valid || commit;
  assign s_xfer   = s_tvalid && s_tready;

  // Results of the item in the input register
  always_comb begin
    r0    = '0;
    r1    = '0;
    res_n = 2'd1;
    r0.last          = 1'b1;
    r0.status        = pk.status;
    r0.words_written = word_count;
    if (pk.status == ST_OK && pk.n != 2'd0) begin
      res_n            = pk.n;
      r0.word          = pk.word0;
      r0.word_valid    = 1'b1;
      r0.last          = (pk.n == 2'd1);
      r0.words_written = word_count + 21'd1;
      r1.word          = pk.word1;
      r1.word_valid    = 1'b1;
      r1.last          = 1'b1;
      r1.status        = ST_OK;
      r1.words_written = word_count + 21'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RST;
      in_valid   <= 1'b0;
      bit_buf    <= '0;
      fill       <= '0;
      word_count <= '0;
      out_cnt    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end

      if (s_xfer) begin
        in_valid <= 1'b1;
      end else if (commit) begin
        in_valid <= 1'b0;
      end

      // Rejected items leave the packer state alone
      if (commit && pk.status == ST_OK) begin
        bit_buf    <= pk.buf_next;
        fill       <= pk.fill_next;
        word_count <= word_count + {19'd0, pk.n};
      end

      if (commit) begin
        out_cnt <= res_n;
      end else if (pop) begin
        out_cnt <= out_cnt - 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_item.req_type    <= s_tuser;
      in_item.value       <= s_tdata[31:0];
      in_item.nbits       <= s_tdata[37:32];
      in_item.flush_after <= s_tlast;
    end
    if (commit) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = {3'd0, slot0.words_written, slot0.word};
  assign m_tuser  = {slot0.status, slot0.word_valid};
  assign m_tlast  = slot0.last;

endmodule

`default_nettype wire

// File: tb/elias_gamma_delta_bit_packer_tb.sv
// Self-checking bench for elias_gamma_delta_bit_packer: random and directed
// raw/gamma/delta items with stream stalls. Needs egd_pkg and the block RTL.
`timescale 1ns / 1ps

module elias_gamma_delta_bit_packer_tb;
  import egd_pkg::*;

  localparam logic [1:0] REQ_BAD    = 2'd3;      // unknown request kind
  localparam int         RUN_LIMIT  = 400000;    // cycles before giving up
  localparam int         HOLD_LEN   = 400;       // long output stall
  localparam int         PRINT_MAX  = 30;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [39:0]       s_tdata   = '0;
  logic [1:0]        s_tuser   = '0;
  logic              s_tlast   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [55:0]       m_tdata;
  logic [2:0]        m_tuser;
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data  = '0;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_request  = 0;
  int cycle_count   = 0;

  always #2 clk = ~clk;

  elias_gamma_delta_bit_packer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Bit-exact packer predictor plus the queue of words it expects back.
  class packer_scoreboard;
    logic [63:0]      pend_bits;
    int unsigned      pend_fill;
    logic [CNT_W-1:0] word_total;
    logic [CNT_W-1:0] cap_words;
    logic [63:0]      work_bits;
    int unsigned      work_fill;
    result_t          expected_words[$];
    int unsigned      errors;

    function new();
      pend_bits  = '0;
      pend_fill  = 0;
      word_total = '0;
      cap_words  = CAPACITY_RST;
      errors     = 0;
    endfunction

    function logic [63:0] ones(int unsigned n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function int unsigned top_bit(logic [63:0] v);
      int unsigned pos;
      pos = 0;
      for (int i = 1; i < 64; i++) begin
        if (v[i]) begin
          pos = i;
        end
      end
      return pos;
    endfunction

    // Shift n code bits into the working buffer; a completed word pops out.
    function bit push_bits(logic [63:0] bits, int unsigned n, output logic [31:0] w);
      w = '0;
      if (n == 0) begin
        return 1'b0;
      end
      work_bits = (work_bits << n) | (bits & ones(n));
      work_fill += n;
      if (work_fill >= 32) begin
        w = 32'(work_bits >> (work_fill - 32));
        work_fill -= 32;
        work_bits &= ones(work_fill);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] v);
      cap_words = v;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void add_expect(logic [31:0] w, logic wv, logic lst, logic [1:0] st);
      result_t r;
      r.word          = w;
      r.word_valid    = wv;
      r.last          = lst;
      r.status        = st;
      r.words_written = word_total;
      expected_words.push_back(r);
    endfunction

    function void note_item(item_t it);
      logic [63:0]      code, v, g;
      int unsigned      len, d, e, total, need, lim;
      logic [1:0]       st;
      logic [31:0]      w;
      logic [31:0]      words [2];
      int               n;
      code = '0;
      len  = 0;
      st   = ST_OK;
      n    = 0;
      lim  = (cap_words < MAX_WORDS) ? cap_words : MAX_WORDS;

      // Rejection priority: bad kind / all-ones value, then nbits, then room.
      if (it.req_type == REQ_BAD || (it.req_type != REQ_RAW && it.value == '1)) begin
        st = ST_RANGE;
      end else if (it.req_type == REQ_RAW) begin
        if (it.nbits > 32) begin
          st = ST_NBITS;
        end else begin
          code = 64'(it.value) & ones(it.nbits);
          len  = it.nbits;
        end
      end else begin
        v = 64'(it.value) + 64'd1;
        d = top_bit(v);
        if (it.req_type == REQ_GAMMA) begin
          code = v;
          len  = 2 * d + 1;
        end else begin
          g    = 64'(d + 1);
          e    = top_bit(g);
          code = (g << d) | (v & ones(d));
          len  = 2 * e + 1 + d;
        end
      end

      if (st == ST_OK) begin
        total = pend_fill + len;
        need  = total / 32 + ((total % 32) != 0);
        if (int'(word_total) + need > lim) begin
          st = ST_OVERFLOW;
        end else if (it.flush_after && need > 2) begin
          st = ST_OVERFLOW;
        end
      end

      if (st != ST_OK) begin
        add_expect('0, 1'b0, 1'b1, st);
        return;
      end

      work_bits = pend_bits;
      work_fill = pend_fill;
      if (len > 32) begin
        if (push_bits(code >> 32, len - 32, w) && n < 2) begin
          words[n] = w;
          n++;
        end
        if (push_bits(code & 64'hFFFF_FFFF, 32, w) && n < 2) begin
          words[n] = w;
          n++;
        end
      end else if (push_bits(code, len, w) && n < 2) begin
        words[n] = w;
        n++;
      end
      if (it.flush_after && work_fill > 0 && n < 2) begin
        words[n] = 32'(work_bits << (32 - work_fill));
        n++;
        work_bits = '0;
        work_fill = 0;
      end
      pend_bits = work_bits & ones(work_fill);
      pend_fill = work_fill % 32;

      if (n == 0) begin
        add_expect('0, 1'b0, 1'b1, ST_OK);
      end
      for (int k = 0; k < n; k++) begin
        word_total = word_total + 1'b1;
        add_expect(words[k], 1'b1, k == n - 1, ST_OK);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= PRINT_MAX) begin
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report("unexpected transfer, word", got.word, 32'h0);
        return;
      end
      want = expected_words.pop_front();
      if (got.word !== want.word) report("word", got.word, want.word);
      if (got.word_valid !== want.word_valid)
        report("word_valid", 32'(got.word_valid), 32'(want.word_valid));
      if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.words_written !== want.words_written)
        report("words_written", 32'(got.words_written), 32'(want.words_written));
    endtask
  endclass

  packer_scoreboard sb = new();

  // Offer one item, with random idle cycles ahead of it; tvalid stays high
  // after the transfer so back-to-back items need no reassertion.
  task send_item(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.nbits, it.value};
    s_tuser  <= it.req_type;
    s_tlast  <= it.flush_after;
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
  endtask

  task send_fields(logic [1:0] kind, logic [31:0] val, logic [5:0] nb, logic fl);
    item_t it;
    it.req_type    = kind;
    it.value       = val;
    it.nbits       = nb;
    it.flush_after = fl;
    send_item(it);
  endtask

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick, width, odd;
    pick           = $urandom_range(99);
    width          = $urandom_range(32);
    odd            = $urandom_range(99);
    it.value       = (width == 32) ? $urandom : ($urandom & ((32'd1 << width) - 32'd1));
    it.nbits       = 6'($urandom_range(63));
    it.flush_after = ($urandom_range(99) < 20);
    if (pick < 4) begin
      it.req_type = REQ_BAD;
    end else if (pick < 42) begin
      it.req_type = REQ_RAW;
      it.value    = $urandom;
      // mostly legal bit counts, a few over 32
      it.nbits    = (odd < 5) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32));
    end else begin
      it.req_type = (pick < 71) ? REQ_GAMMA : REQ_DELTA;
      if (odd < 3) begin
        it.value = '1;
      end else if (odd < 6) begin
        it.value = 32'hFFFF_FFFE;
      end
    end
    return it;
  endfunction

  task send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_item());
    end
  endtask

  // Drop tvalid and let every expected transfer come back.
  task drain;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_capacity(logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(v);
    cfg_valid <= 1'b0;
  endtask

  // Output side: check each transfer, then pick next tready (random, or
  // forced low while a long hold is running).
  initial begin
    result_t got;
    int      hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.word          = m_tdata[31:0];
        got.words_written = m_tdata[52:32];
        got.word_valid    = m_tuser[0];
        got.status        = m_tuser[2:1];
        got.last          = m_tlast;
        sb.check_result(got);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] near_cap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 25;
    rx_idle_pct = 78;

    // Directed: field extremes, each code, each reject path.
    send_fields(REQ_RAW,   32'h0000_0000, 6'd0,  1'b0);  // no word, status only
    send_fields(REQ_RAW,   32'hFFFF_FFFF, 6'd32, 1'b0);  // exactly one word
    send_fields(REQ_RAW,   32'h0000_0001, 6'd1,  1'b1);  // single bit flushed
    send_fields(REQ_GAMMA, 32'h0000_0000, 6'd63, 1'b0);  // shortest gamma
    send_fields(REQ_GAMMA, 32'hFFFF_FFFE, 6'd0,  1'b0);  // longest gamma
    send_fields(REQ_DELTA, 32'hFFFF_FFFE, 6'd0,  1'b1);  // longest delta, flushed
    send_fields(REQ_DELTA, 32'h0000_0000, 6'd0,  1'b0);
    send_fields(REQ_DELTA, 32'h0000_0001, 6'd0,  1'b1);
    send_fields(REQ_BAD,   32'h0000_0005, 6'd0,  1'b0);  // unknown kind
    send_fields(REQ_BAD,   32'h0000_0005, 6'd63, 1'b1);  // range beats nbits
    send_fields(REQ_GAMMA, 32'hFFFF_FFFF, 6'd0,  1'b0);  // all-ones value
    send_fields(REQ_DELTA, 32'hFFFF_FFFF, 6'd0,  1'b1);
    send_fields(REQ_RAW,   32'hFFFF_FFFF, 6'd33, 1'b0);  // nbits just over
    send_fields(REQ_RAW,   32'hFFFF_FFFF, 6'd63, 1'b1);
    send_fields(REQ_RAW,   32'h7FFF_FFFF, 6'd31, 1'b0);  // fill to 31
    send_fields(REQ_GAMMA, 32'hFFFF_FFFE, 6'd0,  1'b1);  // flush needs 3 words
    send_fields(REQ_GAMMA, 32'hFFFF_FFFE, 6'd0,  1'b0);  // same, no flush
    send_fields(REQ_RAW,   32'h0000_0000, 6'd0,  1'b1);
    send_fields(REQ_RAW,   32'h0000_0015, 6'd5,  1'b0);
    send_fields(REQ_RAW,   32'h0000_0000, 6'd0,  1'b1);  // bare flush
    send_fields(REQ_RAW,   32'h0000_000A, 6'd4,  1'b0);
    send_fields(REQ_RAW,   32'h0000_0000, 6'd32, 1'b1);  // word plus flush
    send_fields(REQ_GAMMA, 32'h7FFF_FFFF, 6'd0,  1'b1);
    send_random(500);
    drain();

    // Capacity of one word, already exceeded: nearly everything overflows.
    write_capacity(21'd1);
    send_random(60);
    drain();

    // Capacity just ahead of the count so the overflow edge is crossed.
    tx_idle_pct = 78;
    rx_idle_pct = 25;
    near_cap = sb.word_total + 21'd40;
    write_capacity(near_cap);
    send_random(150);
    drain();

    write_capacity(CAPACITY_RST);
    send_random(450);

    // No idling, with one long output stall to back up the input side.
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = HOLD_LEN;
    send_random(450);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/egd_pkg.sv
hw/rtl/egd_code_gen.sv
hw/rtl/egd_pack.sv
hw/rtl/elias_gamma_delta_bit_packer.sv
tb/elias_gamma_delta_bit_packer_tb.sv
